@@ rtl/hue_wheel_led_buffer_engine_top_defines.svh @@
// Assertion macros shared by the checker file.
`ifndef HUE_WHEEL_LED_BUFFER_ENGINE_TOP_DEFINES_SVH
`define HUE_WHEEL_LED_BUFFER_ENGINE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HWLB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HWLB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/hwlb_pkg.sv @@
package hwlb_pkg;

   typedef enum logic [2:0] {
      FUNC_SET        = 3'd0,
      FUNC_CLEAR      = 3'd1,
      FUNC_FILL       = 3'd2,
      FUNC_FADE_IN    = 3'd3,
      FUNC_FADE_OUT   = 3'd4,
      FUNC_ROTATE_CW  = 3'd5,
      FUNC_ROTATE_CCW = 3'd6,
      FUNC_SHOW       = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_SET,
      OP_CLEAR,
      OP_FILL,
      OP_FADE_IN,
      OP_FADE_OUT,
      OP_ROT_CW,
      OP_ROT_CCW
   } cell_op_type;

   localparam logic [2:0] FULL_LEVEL = 3'd6;
   localparam logic [5:0] STEP_MASK  = 6'd63;

   localparam logic [1:0] PHASE_RED_GREEN  = 2'd0;
   localparam logic [1:0] PHASE_GREEN_BLUE = 2'd1;
   localparam logic [1:0] PHASE_BLUE_RED   = 2'd2;
   localparam logic [1:0] PHASE_SKIP       = 2'd3;

   localparam logic [7:0] GAMMA_LUT [0:63] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,
      8'd1,   8'd1,   8'd2,   8'd2,   8'd3,   8'd3,   8'd4,   8'd5,
      8'd6,   8'd7,   8'd8,   8'd10,  8'd11,  8'd13,  8'd14,  8'd16,
      8'd18,  8'd20,  8'd22,  8'd25,  8'd27,  8'd30,  8'd33,  8'd36,
      8'd39,  8'd43,  8'd47,  8'd50,  8'd55,  8'd59,  8'd63,  8'd68,
      8'd73,  8'd78,  8'd83,  8'd89,  8'd95,  8'd101, 8'd107, 8'd114,
      8'd120, 8'd127, 8'd135, 8'd142, 8'd150, 8'd158, 8'd167, 8'd175,
      8'd184, 8'd193, 8'd203, 8'd213, 8'd223, 8'd233, 8'd244, 8'd255
   };

   typedef struct packed {
      logic [7:0] hue;
      logic [2:0] level;
   } pixel_type;

   typedef struct packed {
      cell_op_type op;
      logic [3:0]  index;
      logic [7:0]  hue;
   } cell_ctrl_type;

   typedef struct packed {
      logic [3:0] number;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       skipped;
      logic       last;
   } rsp_type;

endpackage

@@ rtl/hwlb_cell.sv @@
module hwlb_cell #(
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hwlb_pkg::cell_ctrl_type  ctrl,
   input  hwlb_pkg::pixel_type      prev_pixel,
   input  hwlb_pkg::pixel_type      next_pixel,
   output hwlb_pkg::pixel_type      pixel
);
   import hwlb_pkg::*;

   pixel_type pixel_ff;
   pixel_type pixel_in;

   always_comb begin
      pixel_in = pixel_ff;
      unique case (ctrl.op)
         OP_HOLD: ;
         OP_SET: begin
            if (32'(ctrl.index) == CELL_INDEX) begin
               pixel_in.hue   = ctrl.hue;
               pixel_in.level = FULL_LEVEL;
            end
         end
         OP_CLEAR:    pixel_in.level = 3'd0;
         OP_FILL:     pixel_in.hue   = ctrl.hue;
         OP_FADE_IN: begin
            if (pixel_ff.level < FULL_LEVEL) pixel_in.level = pixel_ff.level + 3'd1;
         end
         OP_FADE_OUT: begin
            if (pixel_ff.level != 3'd0) pixel_in.level = pixel_ff.level - 3'd1;
         end
         OP_ROT_CW:   pixel_in = prev_pixel;
         OP_ROT_CCW:  pixel_in = next_pixel;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_ff <= '0;
      end else begin
         pixel_ff <= pixel_in;
      end
   end

   assign pixel = pixel_ff;

endmodule

@@ rtl/hwlb_color.sv @@
module hwlb_color (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid,
   input  hwlb_pkg::pixel_type  pixel,
   input  logic [3:0]           number,
   input  logic                 last,
   output logic                 rsp_valid,
   output hwlb_pkg::rsp_type    rsp
);
   import hwlb_pkg::*;

   logic [2:0] shift;
   logic [5:0] step;
   logic [7:0] col;
   logic [7:0] ncol;
   rsp_type    rsp_in;
   rsp_type    rsp_ff;
   logic       valid_ff;

   always_comb begin
      // levels above full brightness act as full brightness
      shift  = (pixel.level >= FULL_LEVEL) ? 3'd0 : FULL_LEVEL - pixel.level;
      step   = pixel.hue[5:0];
      col    = GAMMA_LUT[step >> shift];
      ncol   = GAMMA_LUT[(STEP_MASK - step) >> shift];
      rsp_in = '0;
      rsp_in.number = number;
      rsp_in.last   = last;
      unique case (pixel.hue[7:6])
         PHASE_RED_GREEN: begin
            rsp_in.red   = ncol;
            rsp_in.green = col;
         end
         PHASE_GREEN_BLUE: begin
            rsp_in.green = ncol;
            rsp_in.blue  = col;
         end
         PHASE_BLUE_RED: begin
            rsp_in.red   = col;
            rsp_in.blue  = ncol;
         end
         PHASE_SKIP: rsp_in.skipped = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ rtl/hue_wheel_led_buffer_engine_top.sv @@
// Hue-wheel LED pixel buffer. A ring of PIXEL_COUNT cells holds an 8-bit
// hue and a 0..6 brightness level per LED, all zero after reset. A request
// is taken when start is high and busy is low. Set acts on the indexed
// cell; clear, fill, fade in, fade out and both rotations act on every
// cell. All of these act at the accepting clock edge: busy stays low and
// the next request may follow at once. Show raises busy while the ring
// rotates counter-clockwise one place a cycle past cell 0; after a full
// turn the buffer is back where it started. Each pixel leaving cell 0 is
// converted to RGB and registered, so results appear one per cycle, in
// pixel order, the first after the busy register and the result register,
// with rsp_strobe high for exactly one cycle each and rsp_last_pixel on the
// final one. The receiver cannot stall: a result is gone after its cycle,
// so sample every cycle rsp_strobe is high. Hues of 192 and above come out
// with rsp_skipped set and zero color. A set whose index is outside the
// buffer changes nothing. rsp_pixel_number carries the low four bits of
// the pixel index.
module hue_wheel_led_buffer_engine_top #(
   parameter int unsigned PIXEL_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [3:0]  req_pixel_index,
   input  logic [7:0]  req_hue_value,
   output logic        rsp_strobe,
   output logic [3:0]  rsp_pixel_number,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_skipped,
   output logic        rsp_last_pixel
);
   import hwlb_pkg::*;

   localparam int unsigned CNT_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(PIXEL_COUNT - 1);

   logic             busy_ff;
   logic             busy_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             accept;
   logic             show_last;
   cell_ctrl_type    ctrl;
   pixel_type        ring [PIXEL_COUNT];
   rsp_type          rsp;
   logic             rsp_valid;

   assign accept    = start && !busy_ff;
   assign show_last = busy_ff && (count_ff == LAST_COUNT);

   // Decode the request into one broadcast command for every cell.
   always_comb begin
      ctrl.index = req_pixel_index;
      ctrl.hue   = req_hue_value;
      ctrl.op    = OP_HOLD;
      if (busy_ff) begin
         // show in progress: advance the ring past cell 0
         ctrl.op = OP_ROT_CCW;
      end else if (start) begin
         unique case (func_type'(req_func))
            FUNC_SET:        ctrl.op = OP_SET;
            FUNC_CLEAR:      ctrl.op = OP_CLEAR;
            FUNC_FILL:       ctrl.op = OP_FILL;
            FUNC_FADE_IN:    ctrl.op = OP_FADE_IN;
            FUNC_FADE_OUT:   ctrl.op = OP_FADE_OUT;
            FUNC_ROTATE_CW:  ctrl.op = OP_ROT_CW;
            FUNC_ROTATE_CCW: ctrl.op = OP_ROT_CCW;
            FUNC_SHOW:       ctrl.op = OP_HOLD;
         endcase
      end
   end

   // Show sequencer: busy for one pass around the ring.
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      if (busy_ff) begin
         count_in = count_ff + CNT_W'(1);
         if (show_last) begin
            busy_in = 1'b0;
         end
      end else if (accept && (func_type'(req_func) == FUNC_SHOW)) begin
         busy_in  = 1'b1;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   // The ring: cell i takes cell i-1 on a clockwise step, cell i+1 on a
   // counter-clockwise one, with wrap at both ends.
   for (genvar i = 0; i < PIXEL_COUNT; i++) begin : g_cell
      hwlb_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_pixel (ring[(i + PIXEL_COUNT - 1) % PIXEL_COUNT]),
         .next_pixel (ring[(i + 1) % PIXEL_COUNT]),
         .pixel      (ring[i])
      );
   end

   // Convert the pixel at the head of the ring and register the result.
   hwlb_color u_color (
      .clock     (clock),
      .reset     (reset),
      .valid     (busy_ff),
      .pixel     (ring[0]),
      .number    (4'(count_ff)),
      .last      (show_last),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign busy             = busy_ff;
   assign rsp_strobe       = rsp_valid;
   assign rsp_pixel_number = rsp.number;
   assign rsp_red          = rsp.red;
   assign rsp_green        = rsp.green;
   assign rsp_blue         = rsp.blue;
   assign rsp_skipped      = rsp.skipped;
   assign rsp_last_pixel   = rsp.last;

endmodule

@@ rtl/hwlb_checker.sv @@
`include "hue_wheel_led_buffer_engine_top_defines.svh"

module hwlb_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_func,
   input logic        rsp_strobe,
   input logic [3:0]  rsp_pixel_number,
   input logic [7:0]  rsp_red,
   input logic [7:0]  rsp_green,
   input logic [7:0]  rsp_blue,
   input logic        rsp_skipped,
   input logic        rsp_last_pixel
);
   import hwlb_pkg::*;

   logic show_req;
   logic other_req;

   assign show_req  = start && !busy && (func_type'(req_func) == FUNC_SHOW);
   assign other_req = start && !busy && (func_type'(req_func) != FUNC_SHOW);

   // a show request raises busy in the cycle after it is taken
   `HWLB_ASSERT_NEXT(a_show_goes_busy, clock, reset, show_req, busy)

   // other requests finish at once and emit nothing
   `HWLB_ASSERT_NEXT(a_other_quiet, clock, reset, other_req, !busy && !rsp_strobe)

   // results of one show come back to back with rising pixel numbers
   `HWLB_ASSERT_NEXT(a_run_contiguous, clock, reset, rsp_strobe && !rsp_last_pixel,
      rsp_strobe && (rsp_pixel_number == $past(rsp_pixel_number) + 4'd1))

   // a gap always follows the last pixel of a run
   `HWLB_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_strobe && rsp_last_pixel,
      !rsp_strobe)

   // skipped pixels carry no colour
   `HWLB_ASSERT_NOW(a_skip_dark, clock, reset, rsp_strobe && rsp_skipped,
      (rsp_red == 8'd0) && (rsp_green == 8'd0) && (rsp_blue == 8'd0))

endmodule

bind hue_wheel_led_buffer_engine_top hwlb_checker u_hwlb_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_func         (req_func),
   .rsp_strobe       (rsp_strobe),
   .rsp_pixel_number (rsp_pixel_number),
   .rsp_red          (rsp_red),
   .rsp_green        (rsp_green),
   .rsp_blue         (rsp_blue),
   .rsp_skipped      (rsp_skipped),
   .rsp_last_pixel   (rsp_last_pixel)
);
